>>> src/prdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prdt_pkg;

	localparam int CountBits = 16;
	localparam int DataBits = 16;
	localparam int PrescaleBits = 8;
	localparam int DivSelBits = 2;
	localparam int DivCountBits = 4;

	typedef enum logic [1:0] {
		OpTick  = 2'd0,
		OpWrite = 2'd1,
		OpRead  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RegBuffer  = 2'd0,
		RegControl = 2'd1,
		RegCount   = 2'd2,
		RegPending = 2'd3
	} reg_sel_t;

	typedef enum logic [0:0] {
		CfgPrescaler = 1'd0,
		CfgDivSelect = 1'd1
	} cfg_idx_t;

	localparam int CtrlStartBit = 0;
	localparam int CtrlManualBit = 1;
	localparam int CtrlReloadBit = 3;

endpackage

`default_nettype wire

>>> src/prdt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prdt_item_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      operation;
	logic [1:0]                      reg_select;
	logic [prdt_pkg::DataBits-1:0]   write_data;

	modport source (output valid, output operation, output reg_select, output write_data,
		input ready);
	modport sink (input valid, input operation, input reg_select, input write_data,
		output ready);
endinterface

interface prdt_result_if;
	logic                            valid;
	logic                            ready;
	logic [prdt_pkg::DataBits-1:0]   read_data;
	logic                            irq_pending;

	modport source (output valid, output read_data, output irq_pending, input ready);
	modport sink (input valid, input read_data, input irq_pending, output ready);
endinterface

`default_nettype wire

>>> src/prescaled_reload_down_timer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Down-counting timer with a two-stage clock divider and optional auto reload.
// Each accepted item (input clock tick, register write or register read) is
// applied to the timer state at the edge of its transfer, and its single result
// is loaded into the output register at that same edge. One item is accepted
// every cycle while the result side keeps up; a stalled result blocks new
// items only while the output register is full and not taken.

module prescaled_reload_down_timer_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write_en,
	input  wire logic [0:0]                            cfg_index,
	input  wire logic [prdt_pkg::PrescaleBits-1:0]     cfg_data,
	prdt_item_if.sink                                  item,
	prdt_result_if.source                              result
);

	localparam int CB = prdt_pkg::CountBits;
	localparam int DB = prdt_pkg::DataBits;

	logic [prdt_pkg::PrescaleBits-1:0]  prescaler_q;
	logic [prdt_pkg::DivSelBits-1:0]    div_select_q;

	logic [CB-1:0]                      count_buffer_q;
	logic [CB-1:0]                      down_counter_q;
	logic                               run_enable_q;
	logic                               manual_load_q;
	logic                               reload_enable_q;
	logic [prdt_pkg::PrescaleBits-1:0]  prescale_count_q;
	logic [prdt_pkg::DivCountBits-1:0]  divide_count_q;
	logic                               pending_flag_q;

	logic                               result_valid_q;
	logic [DB-1:0]                      read_data_q;
	logic                               irq_pending_q;

	logic [CB-1:0]                      count_buffer_d;
	logic [CB-1:0]                      down_counter_d;
	logic                               run_enable_d;
	logic                               manual_load_d;
	logic                               reload_enable_d;
	logic [prdt_pkg::PrescaleBits-1:0]  prescale_count_d;
	logic [prdt_pkg::DivCountBits-1:0]  divide_count_d;
	logic                               pending_flag_d;
	logic [DB-1:0]                      read_data_d;

	logic                               accept;
	logic [prdt_pkg::DivCountBits-1:0]  div_end;
	logic [CB+DB-1:0]                   wdata_ext;
	logic [CB+DB-1:0]                   buffer_ext;
	logic [CB+DB-1:0]                   counter_ext;
	logic [CB-1:0]                      wdata_cnt;

	assign item.ready = !result_valid_q || result.ready;
	assign accept = item.valid && item.ready;

	assign result.valid = result_valid_q;
	assign result.read_data = read_data_q;
	assign result.irq_pending = irq_pending_q;

	assign div_end = prdt_pkg::DivCountBits'(5'(5'd2 << div_select_q) - 5'd1);
	assign wdata_ext = {{CB{1'b0}}, item.write_data};
	assign wdata_cnt = wdata_ext[CB-1:0];
	assign buffer_ext = {{DB{1'b0}}, count_buffer_q};
	assign counter_ext = {{DB{1'b0}}, down_counter_q};

	always_comb begin
		count_buffer_d = count_buffer_q;
		down_counter_d = down_counter_q;
		run_enable_d = run_enable_q;
		manual_load_d = manual_load_q;
		reload_enable_d = reload_enable_q;
		prescale_count_d = prescale_count_q;
		divide_count_d = divide_count_q;
		pending_flag_d = pending_flag_q;
		read_data_d = '0;
		case (prdt_pkg::op_t'(item.operation))
			prdt_pkg::OpTick: begin
				if (prescale_count_q >= prescaler_q) begin
					prescale_count_d = '0;
					if (divide_count_q >= div_end) begin
						divide_count_d = '0;
						// timer clock
						if (run_enable_q && !manual_load_q) begin
							if (down_counter_q == '0) begin
								pending_flag_d = 1'b1;
								if (reload_enable_q) begin
									down_counter_d = count_buffer_q;
								end else begin
									run_enable_d = 1'b0;
								end
							end else begin
								down_counter_d = down_counter_q - CB'(1);
							end
						end
					end else begin
						divide_count_d = divide_count_q + prdt_pkg::DivCountBits'(1);
					end
				end else begin
					prescale_count_d = prescale_count_q + prdt_pkg::PrescaleBits'(1);
				end
			end
			prdt_pkg::OpWrite: begin
				case (prdt_pkg::reg_sel_t'(item.reg_select))
					prdt_pkg::RegBuffer: begin
						count_buffer_d = wdata_cnt;
					end
					prdt_pkg::RegControl: begin
						run_enable_d = item.write_data[prdt_pkg::CtrlStartBit];
						manual_load_d = item.write_data[prdt_pkg::CtrlManualBit];
						reload_enable_d = item.write_data[prdt_pkg::CtrlReloadBit];
						if (item.write_data[prdt_pkg::CtrlManualBit]) begin
							down_counter_d = count_buffer_q;
						end
					end
					prdt_pkg::RegPending: begin
						if (item.write_data[0]) begin
							pending_flag_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			prdt_pkg::OpRead: begin
				case (prdt_pkg::reg_sel_t'(item.reg_select))
					prdt_pkg::RegBuffer: begin
						read_data_d = buffer_ext[DB-1:0];
					end
					prdt_pkg::RegControl: begin
						read_data_d[prdt_pkg::CtrlStartBit] = run_enable_q;
						read_data_d[prdt_pkg::CtrlManualBit] = manual_load_q;
						read_data_d[prdt_pkg::CtrlReloadBit] = reload_enable_q;
					end
					prdt_pkg::RegCount: begin
						read_data_d = counter_ext[DB-1:0];
					end
					default: begin
						read_data_d = DB'(pending_flag_q);
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			div_select_q <= '0;
		end else if (cfg_write_en) begin
			case (prdt_pkg::cfg_idx_t'(cfg_index))
				prdt_pkg::CfgPrescaler: prescaler_q <= cfg_data;
				prdt_pkg::CfgDivSelect: div_select_q <= cfg_data[prdt_pkg::DivSelBits-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_buffer_q <= '0;
			down_counter_q <= '0;
			run_enable_q <= 1'b0;
			manual_load_q <= 1'b0;
			reload_enable_q <= 1'b0;
			prescale_count_q <= '0;
			divide_count_q <= '0;
			pending_flag_q <= 1'b0;
		end else if (accept) begin
			count_buffer_q <= count_buffer_d;
			down_counter_q <= down_counter_d;
			run_enable_q <= run_enable_d;
			manual_load_q <= manual_load_d;
			reload_enable_q <= reload_enable_d;
			prescale_count_q <= prescale_count_d;
			divide_count_q <= divide_count_d;
			pending_flag_q <= pending_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item.ready) begin
			result_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= read_data_d;
			irq_pending_q <= pending_flag_d;
		end
	end

	a_prescale_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.operation != prdt_pkg::OpTick) |=> $stable(prescale_count_q))
		else $error("prescale count moved on a bus transfer");

	a_manual_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && manual_load_q && !(item.operation == prdt_pkg::OpWrite
			&& item.reg_select == prdt_pkg::RegControl)) |=> $stable(down_counter_q))
		else $error("counter moved while manual update held");

	a_irq_matches: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (result.irq_pending == pending_flag_q))
		else $error("reported pending flag differs from state");

	a_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.operation == prdt_pkg::OpWrite
			&& item.reg_select == prdt_pkg::RegPending && item.write_data[0])
		|=> !pending_flag_q)
		else $error("pending flag not cleared by write");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item.ready)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> tb/sv/prescaled_reload_down_timer_core_tb.sv
`timescale 1ns / 1ps

module prescaled_reload_down_timer_core_tb;

	localparam logic [1:0] OpIdle = 2'd3;
	localparam int NumPhases = 8;
	localparam int PhaseOps = 110;

	typedef struct packed {
		logic [1:0]                    op;
		logic [1:0]                    sel;
		logic [prdt_pkg::DataBits-1:0] wd;
	} bus_op_t;

	typedef struct packed {
		logic [prdt_pkg::DataBits-1:0] read_data;
		logic                          irq_pending;
	} reply_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [0:0] cfg_index;
	logic [prdt_pkg::PrescaleBits-1:0] cfg_data;

	prdt_item_if item_ch ();
	prdt_result_if result_ch ();

	prescaled_reload_down_timer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item_ch),
		.result       (result_ch)
	);

	// timer model state
	logic [prdt_pkg::PrescaleBits-1:0] prescale_cfg;
	logic [prdt_pkg::DivSelBits-1:0]   div_sel_cfg;
	logic [prdt_pkg::CountBits-1:0]    count_buf;
	logic [prdt_pkg::CountBits-1:0]    counter_val;
	logic                              run_en;
	logic                              manual_ld;
	logic                              reload_en;
	logic [prdt_pkg::PrescaleBits-1:0] prescale_cnt;
	logic [prdt_pkg::DivCountBits-1:0] divide_cnt;
	logic                              pend;

	bus_op_t bus_ops_q[$];
	reply_t  expected_replies[$];
	bus_op_t queued_op;
	reply_t  got_reply;
	reply_t  want_reply;
	int      mismatches;
	int      send_gap;
	int      stall_left;
	bit      gaps_on;
	bit      item_taken;
	int      phase_presc[NumPhases];
	int      phase_dsel[NumPhases];

	always #4 clk = ~clk;

	function automatic reply_t timer_apply(input bus_op_t it);
		reply_t r;
		logic [4:0] div_end;
		r.read_data = '0;
		case (it.op)
			prdt_pkg::OpTick: begin
				div_end = 5'(5'd2 << div_sel_cfg) - 5'd1;
				if (prescale_cnt >= prescale_cfg) begin
					prescale_cnt = '0;
					if ({1'b0, divide_cnt} >= div_end) begin
						divide_cnt = '0;
						if (run_en && !manual_ld) begin
							if (counter_val == '0) begin
								pend = 1'b1;
								if (reload_en)
									counter_val = count_buf;
								else
									run_en = 1'b0;
							end else begin
								counter_val = counter_val - prdt_pkg::CountBits'(1);
							end
						end
					end else begin
						divide_cnt = divide_cnt + prdt_pkg::DivCountBits'(1);
					end
				end else begin
					prescale_cnt = prescale_cnt + prdt_pkg::PrescaleBits'(1);
				end
			end
			prdt_pkg::OpWrite: begin
				case (it.sel)
					prdt_pkg::RegBuffer: count_buf = it.wd[prdt_pkg::CountBits-1:0];
					prdt_pkg::RegControl: begin
						run_en = it.wd[prdt_pkg::CtrlStartBit];
						manual_ld = it.wd[prdt_pkg::CtrlManualBit];
						reload_en = it.wd[prdt_pkg::CtrlReloadBit];
						if (manual_ld)
							counter_val = count_buf;
					end
					prdt_pkg::RegPending: begin
						if (it.wd[0])
							pend = 1'b0;
					end
					default: ;
				endcase
			end
			prdt_pkg::OpRead: begin
				case (it.sel)
					prdt_pkg::RegBuffer: r.read_data = count_buf;
					prdt_pkg::RegControl: begin
						r.read_data[prdt_pkg::CtrlStartBit] = run_en;
						r.read_data[prdt_pkg::CtrlManualBit] = manual_ld;
						r.read_data[prdt_pkg::CtrlReloadBit] = reload_en;
					end
					prdt_pkg::RegCount: r.read_data = counter_val;
					default: r.read_data = {{(prdt_pkg::DataBits-1){1'b0}}, pend};
				endcase
			end
			default: ;
		endcase
		r.irq_pending = pend;
		return r;
	endfunction

	// accepted transfers on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				queued_op.op = item_ch.operation;
				queued_op.sel = item_ch.reg_select;
				queued_op.wd = item_ch.write_data;
				expected_replies.push_back(timer_apply(queued_op));
				item_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual read_data %h irq %b",
						$time, result_ch.read_data, result_ch.irq_pending);
				end else begin
					want_reply = expected_replies.pop_front();
					got_reply.read_data = result_ch.read_data;
					got_reply.irq_pending = result_ch.irq_pending;
					if (got_reply.read_data !== want_reply.read_data) begin
						mismatches++;
						$display("%0t: read_data expected %h actual %h",
							$time, want_reply.read_data, got_reply.read_data);
					end
					if (got_reply.irq_pending !== want_reply.irq_pending) begin
						mismatches++;
						$display("%0t: irq_pending expected %b actual %b",
							$time, want_reply.irq_pending, got_reply.irq_pending);
					end
				end
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		if (item_ch.valid && !item_taken) begin
		end else if (send_gap > 0) begin
			send_gap--;
			item_ch.valid <= 1'b0;
		end else if (bus_ops_q.size() > 0 && gaps_on && $urandom_range(0, 99) < 10) begin
			send_gap = $urandom_range(1, 18) - 1;
			item_ch.valid <= 1'b0;
		end else if (bus_ops_q.size() > 0) begin
			queued_op = bus_ops_q.pop_front();
			item_ch.valid <= 1'b1;
			item_ch.operation <= queued_op.op;
			item_ch.reg_select <= queued_op.sel;
			item_ch.write_data <= queued_op.wd;
		end else begin
			item_ch.valid <= 1'b0;
		end
		item_taken = 1'b0;
	end

	// result backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 99) < 10) begin
			stall_left = $urandom_range(1, 18) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic push_op(input logic [1:0] op, input logic [1:0] sel,
		input logic [prdt_pkg::DataBits-1:0] wd);
		bus_op_t it;
		it.op = op;
		it.sel = sel;
		it.wd = wd;
		bus_ops_q.push_back(it);
	endtask

	task automatic push_random_op();
		int roll;
		logic [1:0] sel;
		logic [prdt_pkg::DataBits-1:0] wd;
		roll = $urandom_range(0, 99);
		sel = 2'($urandom_range(0, 3));
		wd = 16'($urandom);
		if (roll < 55) begin
			push_op(prdt_pkg::OpTick, sel, wd);
		end else if (roll < 58) begin
			push_op(OpIdle, sel, wd);
		end else if (roll < 80) begin
			if (sel == prdt_pkg::RegBuffer && $urandom_range(0, 9) < 8) begin
				wd = 16'($urandom_range(0, 6));
			end else if (sel == prdt_pkg::RegControl && $urandom_range(0, 9) < 7) begin
				wd = '0;
				wd[prdt_pkg::CtrlStartBit] = 1'b1;
				wd[prdt_pkg::CtrlReloadBit] = 1'($urandom_range(0, 1));
				wd[prdt_pkg::CtrlManualBit] = ($urandom_range(0, 9) == 0);
			end
			push_op(prdt_pkg::OpWrite, sel, wd);
		end else begin
			push_op(prdt_pkg::OpRead, sel, wd);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (bus_ops_q.size() != 0 || item_ch.valid || expected_replies.size() != 0);
	endtask

	task automatic write_timer_cfg(input logic [prdt_pkg::PrescaleBits-1:0] presc,
		input logic [prdt_pkg::DivSelBits-1:0] dsel);
		logic [prdt_pkg::PrescaleBits-1:0] word;
		word = 8'($urandom);
		word[prdt_pkg::DivSelBits-1:0] = dsel;
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= prdt_pkg::CfgPrescaler;
		cfg_data <= presc;
		@(negedge clk);
		cfg_index <= prdt_pkg::CfgDivSelect;
		cfg_data <= word;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		prescale_cfg = presc;
		div_sel_cfg = word[prdt_pkg::DivSelBits-1:0];
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = prdt_pkg::CfgPrescaler;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = prdt_pkg::OpTick;
		item_ch.reg_select = prdt_pkg::RegBuffer;
		item_ch.write_data = '0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		send_gap = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		item_taken = 1'b0;
		prescale_cfg = '0;
		div_sel_cfg = '0;
		count_buf = '0;
		counter_val = '0;
		run_en = 1'b0;
		manual_ld = 1'b0;
		reload_en = 1'b0;
		prescale_cnt = '0;
		divide_cnt = '0;
		pend = 1'b0;
		phase_presc = '{0, 255, 1, 0, 3, 255, 2, 0};
		phase_dsel = '{0, 3, 1, 3, 2, 0, 1, 0};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values, counter expiry with reload, pending flag and manual update
		push_op(prdt_pkg::OpRead, prdt_pkg::RegBuffer, 16'h0000);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegControl, 16'hFFFF);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegCount, 16'h0000);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegPending, 16'h0000);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegBuffer, 16'hFFFF);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegBuffer, 16'h0000);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegBuffer, 16'h0003);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegControl, 16'h0009);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegControl, 16'h0000);
		repeat (4) push_op(prdt_pkg::OpTick, prdt_pkg::RegBuffer, 16'h0000);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegCount, 16'h0000);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegPending, 16'h0000);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegPending, 16'hFFFE);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegPending, 16'h0001);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegCount, 16'hFFFF);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegCount, 16'h0000);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegControl, 16'h0002);
		repeat (2) push_op(prdt_pkg::OpTick, prdt_pkg::RegControl, 16'hFFFF);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegControl, 16'hFFFF);
		push_op(prdt_pkg::OpRead, prdt_pkg::RegControl, 16'h0000);
		push_op(OpIdle, prdt_pkg::RegPending, 16'hFFFF);
		push_op(prdt_pkg::OpWrite, prdt_pkg::RegControl, 16'h0001);
		wait_drained();

		for (int p = 0; p < NumPhases; p++) begin
			write_timer_cfg(8'(phase_presc[p]), 2'(phase_dsel[p]));
			if (p == NumPhases - 1)
				gaps_on = 1'b0;
			repeat (PhaseOps / 2) push_random_op();
			wait_drained();
			repeat (PhaseOps - PhaseOps / 2) push_random_op();
			wait_drained();
		end

		repeat (5) @(posedge clk);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("prescaled_reload_down_timer_core test passed");
		end else begin
			$display("prescaled_reload_down_timer_core test failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("prescaled_reload_down_timer_core test failed");
		$finish;
	end

endmodule

>>> sim.f
src/prdt_pkg.sv
src/prdt_if.sv
src/prescaled_reload_down_timer_core.sv
tb/sv/prescaled_reload_down_timer_core_tb.sv
